// ===== hdl/aod_pkg.sv =====
// ---------------------------------------------------------------------------
// aod_pkg: shared types and constants for the orientation debouncer
// Register indexes, configuration and stage control structs.
// ---------------------------------------------------------------------------
`default_nettype none

package aod_pkg;

   localparam int THR_W  = 15;
   localparam int THR_SQ_W = 2 * THR_W;
   localparam int DEB_W  = 4;
   localparam int ROT_W  = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FLAT_THRESHOLD      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_COUNT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOUNT_QUARTER_TURNS = 2'd2;

   localparam logic [THR_W-1:0] FLAT_THRESHOLD_RESET      = 15'd7373;
   localparam logic [DEB_W-1:0] DEBOUNCE_COUNT_RESET      = 4'd5;
   localparam logic [ROT_W-1:0] MOUNT_QUARTER_TURNS_RESET = 2'd0;

   typedef struct packed {
      logic              kind;
      logic [ROT_W-1:0]  forced_rotation;
      logic [ROT_W-1:0]  sector;
   } item_ctl_type;

   typedef struct packed {
      logic [THR_SQ_W-1:0] thr_sq;
      logic [DEB_W-1:0]    debounce_count;
      logic [ROT_W-1:0]    mount_quarter_turns;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hdl/accel_orientation_debounce.sv =====
// Registers: a request beat is captured by the input register on acceptance, and
// its response beat by the result register (no other register between them).
// Throughput: one beat per cycle; squares, flat compare and the debounce
// state update all fit between the two registers. A held response stalls input.
// Reset: synchronous; clears valids, rotation state and restores
// register defaults (threshold 7373, debounce 5, mount 0).
// ---------------------------------------------------------------------------
// accel_orientation_debounce: screen orientation from accelerometer X/Y
// Configuration registers, threshold squaring and the two pipeline parts.
// ---------------------------------------------------------------------------
`default_nettype none

module accel_orientation_debounce #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_kind,
   input  wire signed [SAMPLE_WIDTH-1:0]      req_accel_x,
   input  wire signed [SAMPLE_WIDTH-1:0]      req_accel_y,
   input  wire [aod_pkg::ROT_W-1:0]           req_forced_rotation,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [aod_pkg::ROT_W-1:0]          rsp_rotation,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [aod_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [aod_pkg::THR_W-1:0]           csr_wdata
);

   logic [aod_pkg::THR_W-1:0]     thr_ff;
   logic [aod_pkg::THR_SQ_W-1:0]  thr_sq_ff;
   logic [aod_pkg::DEB_W-1:0]     deb_ff;
   logic [aod_pkg::ROT_W-1:0]     mount_ff;

   aod_pkg::cfg_type              cfg;
   logic                          s2_valid, s2_ready;
   aod_pkg::item_ctl_type         s2_ctl;
   logic [2*SAMPLE_WIDTH-1:0]     s2_sq_x, s2_sq_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= aod_pkg::FLAT_THRESHOLD_RESET;
         deb_ff   <= aod_pkg::DEBOUNCE_COUNT_RESET;
         mount_ff <= aod_pkg::MOUNT_QUARTER_TURNS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            aod_pkg::CSR_FLAT_THRESHOLD:      thr_ff   <= csr_wdata;
            aod_pkg::CSR_DEBOUNCE_COUNT:      deb_ff   <= csr_wdata[aod_pkg::DEB_W-1:0];
            aod_pkg::CSR_MOUNT_QUARTER_TURNS: mount_ff <= csr_wdata[aod_pkg::ROT_W-1:0];
            default: ;
         endcase
      end
   end

   // threshold squared, registered from the threshold register
   always_ff @(posedge clock) begin
      thr_sq_ff <= thr_ff * thr_ff;
   end

   always_comb begin
      cfg.thr_sq              = thr_sq_ff;
      cfg.debounce_count      = deb_ff;
      cfg.mount_quarter_turns = mount_ff;
   end

   aod_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_forced_rotation (req_forced_rotation),
      .s2_valid            (s2_valid),
      .s2_ready            (s2_ready),
      .s2_ctl              (s2_ctl),
      .s2_sq_x             (s2_sq_x),
      .s2_sq_y             (s2_sq_y)
   );

   aod_track #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) u_track (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .s2_valid     (s2_valid),
      .s2_ready     (s2_ready),
      .s2_ctl       (s2_ctl),
      .s2_sq_x      (s2_sq_x),
      .s2_sq_y      (s2_sq_y),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_rotation (rsp_rotation)
   );

endmodule

`default_nettype wire

// ===== hdl/aod_front.sv =====
// ---------------------------------------------------------------------------
// aod_front: input register, squares and sector decode
// Registers the request beat and derives x*x, y*y and the raw sector from it.
// ---------------------------------------------------------------------------
`default_nettype none

module aod_front #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_kind,
   input  wire signed [SAMPLE_WIDTH-1:0]    req_accel_x,
   input  wire signed [SAMPLE_WIDTH-1:0]    req_accel_y,
   input  wire [aod_pkg::ROT_W-1:0]         req_forced_rotation,
   output logic                             s2_valid,
   input  wire                              s2_ready,
   output aod_pkg::item_ctl_type            s2_ctl,
   output logic [2*SAMPLE_WIDTH-1:0]        s2_sq_x,
   output logic [2*SAMPLE_WIDTH-1:0]        s2_sq_y
);

   localparam int W = SAMPLE_WIDTH;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_kind_ff;
   logic [aod_pkg::ROT_W-1:0]     s1_forced_ff;
   logic signed [W-1:0]           s1_x_ff, s1_y_ff;

   logic                          en1;
   logic signed [2*W-1:0]         prod_x, prod_y;
   logic signed [W:0]             xe, ye, nye;
   logic [aod_pkg::ROT_W-1:0]     sector;

   assign en1 = !s1_valid_ff || s2_ready;
   assign req_ready = en1;

   assign s1_valid_in = en1 ? req_valid : s1_valid_ff;

   assign prod_x = s1_x_ff * s1_x_ff;
   assign prod_y = s1_y_ff * s1_y_ff;

   assign xe  = {s1_x_ff[W-1], s1_x_ff};
   assign ye  = {s1_y_ff[W-1], s1_y_ff};
   assign nye = -ye;

   always_comb begin
      priority if (xe >= ye && xe > nye) begin
         sector = 2'd1;
      end else if (xe > ye && xe <= nye) begin
         sector = 2'd2;
      end else if (xe <= ye && xe < nye) begin
         sector = 2'd3;
      end else begin
         sector = 2'd0;
      end
   end

   always_comb begin
      s2_ctl.kind            = s1_kind_ff;
      s2_ctl.forced_rotation = s1_forced_ff;
      s2_ctl.sector          = sector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_kind_ff   <= req_kind;
         s1_forced_ff <= req_forced_rotation;
         s1_x_ff      <= req_accel_x;
         s1_y_ff      <= req_accel_y;
      end
   end

   assign s2_valid = s1_valid_ff;
   assign s2_sq_x  = prod_x;
   assign s2_sq_y  = prod_y;

endmodule

`default_nettype wire

// ===== hdl/aod_track.sv =====
// ---------------------------------------------------------------------------
// aod_track: flat test, debounce state and result register
// Compares the squared magnitude against the squared threshold and updates the rotation.
// ---------------------------------------------------------------------------
`default_nettype none

module aod_track #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  aod_pkg::cfg_type                 cfg,
   input  wire                              s2_valid,
   output logic                             s2_ready,
   input  aod_pkg::item_ctl_type            s2_ctl,
   input  wire [2*SAMPLE_WIDTH-1:0]         s2_sq_x,
   input  wire [2*SAMPLE_WIDTH-1:0]         s2_sq_y,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [aod_pkg::ROT_W-1:0]        rsp_rotation
);

   localparam int W = SAMPLE_WIDTH;
   localparam int CMP_W = (2 * W + 1 > aod_pkg::THR_SQ_W) ? 2 * W + 1 : aod_pkg::THR_SQ_W;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [aod_pkg::ROT_W-1:0]     rsp_rotation_ff;
   logic [aod_pkg::ROT_W-1:0]     cur_ff, cur_in;
   logic [aod_pkg::ROT_W-1:0]     cand_ff, cand_in;
   logic [aod_pkg::DEB_W-1:0]     cnt_ff, cnt_in;

   logic                          upd;
   logic [CMP_W-1:0]              mag2, thr_sq;
   logic                          flat;
   logic [aod_pkg::ROT_W-1:0]     prop;
   logic [aod_pkg::DEB_W-1:0]     inc;

   assign s2_ready = !rsp_valid_ff || rsp_ready;
   assign upd = s2_valid && s2_ready;

   assign mag2   = CMP_W'(s2_sq_x) + CMP_W'(s2_sq_y);
   assign thr_sq = CMP_W'(cfg.thr_sq);
   assign flat   = mag2 < thr_sq;
   assign prop   = flat ? cur_ff : aod_pkg::ROT_W'(s2_ctl.sector + cfg.mount_quarter_turns);
   assign inc    = cnt_ff + 4'd1;

   always_comb begin
      cur_in  = cur_ff;
      cand_in = cand_ff;
      cnt_in  = cnt_ff;
      if (upd) begin
         priority if (s2_ctl.kind) begin
            cur_in  = s2_ctl.forced_rotation;
            cand_in = s2_ctl.forced_rotation;
            cnt_in  = '0;
         end else if (prop == cur_ff) begin
            cnt_in = '0;
         end else if (prop == cand_ff) begin
            if (inc >= cfg.debounce_count) begin
               cur_in = prop;
               cnt_in = '0;
            end else begin
               cnt_in = inc;
            end
         end else begin
            cand_in = prop;
            cnt_in  = '0;
         end
      end
   end

   assign rsp_valid_in = s2_ready ? s2_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         cand_ff      <= '0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         cand_ff      <= cand_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd) begin
         rsp_rotation_ff <= cur_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rotation = rsp_rotation_ff;

   a_count_implies_new_candidate: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> cand_ff != cur_ff)
      else $error("stable count running with candidate equal to current");

   a_force_sets_rotation: assert property (@(posedge clock) disable iff (reset)
      upd && s2_ctl.kind |=> cur_ff == $past(s2_ctl.forced_rotation) && cnt_ff == '0
         && cand_ff == cur_ff)
      else $error("force beat did not set rotation state");

   a_result_tracks_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_rotation_ff == cur_ff)
      else $error("pending result differs from current rotation");

endmodule

`default_nettype wire
